@@ rtl/bvs_pkg.sv @@
// Package for the bidirectional value sorter: beat types, sequencer states
// and default sizing. No dependencies.
package bvs_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               batch_end;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               run_end;
        logic               overflow_seen;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_I,
        ST_SORT_V,
        ST_SORT_C,
        ST_SORT_P,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } seq_state_t;

endpackage

@@ rtl/bvs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module bvs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bidirectional_value_sorter_unit.sv @@
// Top level of the bidirectional value sorter.
// Depends on bvs_pkg and bvs_ram.

// Values stream in one beat per cycle while the block is loading and are
// written straight into a CAPACITY-entry RAM; beats past capacity are
// dropped and flag the run as overflowed. The beat with batch_end closes the
// batch: the block then insertion-sorts the RAM in place (ascending, or
// descending when the direction register written by cfg_data is 1) and
// emits the batch as a run of output beats, the last one marked run_end.
// Sorting a batch of n values takes at most n(n-1)/2 element shifts, one per
// cycle, through the single RAM read port with its registered read. Each
// output beat is read from RAM, loaded into the output register and held
// until accepted. No input beat is taken from batch close until the last
// beat of the run is accepted.
module bidirectional_value_sorter_unit
    import bvs_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic          desc_reg;
    logic signed [31:0] v_reg, v_next;
    logic          out_valid_reg, out_valid_next;
    out_beat_t     out_reg, out_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          in_acc, out_acc, goes_first, has_room;

    bvs_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_acc   = out_valid_reg && out_ready;
    assign has_room  = (count_reg < CAP_C);

    // Held value moves ahead of the entry just read from RAM.
    assign goes_first = desc_reg ? (v_reg > $signed(ram_rdata))
                                 : (v_reg < $signed(ram_rdata));

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && in_data.batch_end)
                begin
                    state_next = ST_SORT_I;
                end
            end
            ST_SORT_I:
            begin
                state_next = (i_reg >= count_reg) ? ST_EMIT_RD : ST_SORT_V;
            end
            ST_SORT_V:    state_next = ST_SORT_C;
            ST_SORT_C:
            begin
                if (!goes_first || j_reg == ONE_C)
                begin
                    state_next = ST_SORT_P;
                end
            end
            ST_SORT_P:    state_next = ST_SORT_I;
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    state_next = out_reg.run_end ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    // Datapath, RAM port control and counters.
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = in_data.sample_value;
        ram_raddr      = i_reg[AW-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                i_next = ONE_C;
                k_next = '0;
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + ONE_C;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SORT_I:
            begin
                ram_raddr = i_reg[AW-1:0];
            end
            ST_SORT_V:
            begin
                v_next    = ram_rdata;
                j_next    = i_reg;
                ram_raddr = AW'(i_reg - ONE_C);
            end
            ST_SORT_C:
            begin
                ram_raddr = AW'(j_reg - CW'(2));
                if (goes_first)
                begin
                    // Shift the entry read from RAM up one slot.
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - ONE_C;
                end
            end
            ST_SORT_P:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = v_reg;
                i_next    = i_reg + ONE_C;
            end
            ST_EMIT_RD:
            begin
                ram_raddr = k_reg[AW-1:0];
            end
            ST_EMIT_LD:
            begin
                out_valid_next         = 1'b1;
                out_next.sorted_value  = ram_rdata;
                out_next.run_end       = (k_reg + ONE_C == count_reg);
                out_next.overflow_seen = ovf_reg;
            end
            ST_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + ONE_C;
                    if (out_reg.run_end)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_data;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        out_reg <= out_next;
    end

endmodule

@@ sim/bidirectional_value_sorter_unit_tb.sv @@
// Self-checking testbench for the bidirectional value sorter: drives batches of
// signed Q16.16 beats, predicts each sorted run and checks every output beat.
// Depends on bvs_pkg and the bidirectional_value_sorter_unit RTL.
module bidirectional_value_sorter_unit_tb
    import bvs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = CAPACITY_DEF;

    // Keeps a copy of the sorter's store, predicts each run, checks out beats.
    class sort_scoreboard;
        logic signed [31:0] held_q[$];
        logic               dropped = 1'b0;
        logic               descending = 1'b0;
        out_beat_t          pending_q[$];
        int                 errors;

        function void note_input(in_beat_t b);
            logic signed [31:0] v;
            int j;
            out_beat_t o;
            if (held_q.size() < DEPTH)
                held_q.push_back(b.sample_value);
            else
                dropped = 1'b1;
            if (!b.batch_end)
                return;
            // insertion sort, signed compare, direction from the register
            for (int i = 1; i < held_q.size(); i++)
            begin
                v = held_q[i];
                j = i;
                while (j > 0 && (descending ? (v > held_q[j-1]) : (v < held_q[j-1])))
                begin
                    held_q[j] = held_q[j-1];
                    j--;
                end
                held_q[j] = v;
            end
            foreach (held_q[k])
            begin
                o.sorted_value  = held_q[k];
                o.run_end       = (k == held_q.size() - 1);
                o.overflow_seen = dropped;
                pending_q.push_back(o);
            end
            held_q.delete();
            dropped = 1'b0;
        endfunction

        function void check_output(out_beat_t got);
            out_beat_t exp_b;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $realtime, got);
                errors++;
                return;
            end
            exp_b = pending_q.pop_front();
            if (got.sorted_value !== exp_b.sorted_value)
            begin
                $display("%0t: sorted_value expected %0d actual %0d", $realtime,
                         exp_b.sorted_value, got.sorted_value);
                errors++;
            end
            if (got.run_end !== exp_b.run_end)
            begin
                $display("%0t: run_end expected %b actual %b", $realtime,
                         exp_b.run_end, got.run_end);
                errors++;
            end
            if (got.overflow_seen !== exp_b.overflow_seen)
            begin
                $display("%0t: overflow_seen expected %b actual %b", $realtime,
                         exp_b.overflow_seen, got.overflow_seen);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    sort_scoreboard sb = new();
    int  sink_holdoff = 0;   // long receiver stall requested by the stimulus
    bit  sink_burst   = 0;   // when set, the receiver never idles

    always #6 clk = ~clk;

    bidirectional_value_sorter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Send one input beat, then, if gaps is set, hold valid low for a random gap.
    task automatic send_sample(logic signed [31:0] value, logic last, bit gaps);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{sample_value: value, batch_end: last};
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_input(in_data);
        gap = gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every predicted beat has drained, then let the sorter settle.
    task automatic wait_idle();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write the direction register; only ever called while the block is idle.
    task automatic write_direction(logic desc);
        cfg_valid <= 1'b1;
        cfg_data  <= desc;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.descending = desc;
        cfg_valid <= 1'b0;
    endtask

    // Random value: mostly spread, sometimes extremes or a small set to force ties.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 6)) - 32'd3);
            default: return $signed($urandom());
        endcase
    endfunction

    // Send one batch of len values; the last one carries batch_end.
    task automatic send_batch(int len, bit gaps);
        for (int i = 0; i < len; i++)
            send_sample(pick_value(), i == len - 1, gaps);
    endtask

    // Receiver: random stalls, a burst mode, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_output(out_data);
    end

    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (sink_holdoff > 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_holdoff) @(posedge clk);
                sink_holdoff = 0;
            end
            wait_cycles = sink_burst ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 2) == 0)
                wait_cycles = 0;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready) && sink_holdoff == 0);
        end
    end

    initial
    begin
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, single value, ties, both directions.
        send_sample(32'sh7FFF_FFFF, 1'b0, 0);
        send_sample(32'sh8000_0000, 1'b0, 0);
        send_sample(32'sh0000_0000, 1'b0, 0);
        send_sample(-32'sd1, 1'b0, 0);
        send_sample(32'sh0001_0000, 1'b1, 0);
        send_sample(32'sh1234_5678, 1'b1, 0);
        send_sample(32'sd5, 1'b0, 0);
        send_sample(32'sd5, 1'b0, 0);
        send_sample(-32'sd5, 1'b1, 0);
        drop_valid();
        wait_idle();
        write_direction(1'b1);
        send_sample(32'sh8000_0000, 1'b0, 0);
        send_sample(32'sh7FFF_FFFF, 1'b0, 0);
        send_sample(32'sh5555_AAAA, 1'b0, 0);
        send_sample(32'shAAAA_5555, 1'b1, 0);
        send_sample(-32'sd7, 1'b1, 1);

        // Overflow: capacity plus a few, sender keeps offering while the
        // receiver is held off past the sort so the block stalls its input.
        drop_valid();
        wait_idle();
        sink_holdoff = 3000;
        send_batch(DEPTH + 3, 0);
        send_batch(3, 0);
        // An exactly full batch, then a full batch closed by a dropped beat.
        send_batch(DEPTH, 0);
        drop_valid();
        wait_idle();
        write_direction(1'b0);
        for (int i = 0; i < DEPTH; i++)
            send_sample($signed($urandom()), 1'b0, 0);
        send_sample(32'sd42, 1'b1, 0);
        drop_valid();
        wait_idle();

        // Random: mostly short batches, a few large, direction flips per phase.
        sent = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_direction(phase[0]);
            sink_burst = (phase == 2);
            for (int b = 0; b < 3; b++)
            begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, DEPTH + 2)
                                                  : $urandom_range(1, 6);
                send_batch(len, phase != 2);
                sent += len;
            end
            drop_valid();
            wait_idle();
            if (sent > 120)
                break;
        end
        sink_burst = 0;

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
